@@ sv/assert_macros.svh @@
// Assertion macros used by the timer bank RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define TMB_ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define TMB_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/tmb_pkg.sv @@
// Package for the multi-timer bank: constants, operation codes, sequencer states, entry and item types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tmb_pkg;

  localparam int TIMER_COUNT = 16;
  localparam int IDX_W       = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
  localparam int CNT_W       = $clog2(TIMER_COUNT + 1);
  localparam int TIME_W      = 48;
  localparam int PER_W       = 31;
  localparam int MASK_W      = 16;

  typedef enum logic [2:0] {
    OP_TICK     = 3'd0,
    OP_REGISTER = 3'd1,
    OP_ENABLE   = 3'd2,
    OP_DISABLE  = 3'd3,
    OP_DECREASE = 3'd4,
    OP_TRIGGER  = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMD,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [TIME_W-1:0] deadline;
    logic [PER_W-1:0]  period;
    logic              repeat_flag;
    logic              armed;
  } entry_t;

  typedef struct packed {
    op_t               op;
    logic [3:0]        sel;
    logic [TIME_W-1:0] now;
    logic [PER_W-1:0]  interval;
    logic              recurring;
    logic [PER_W-1:0]  amount;
    logic [PER_W-1:0]  minimum;
  } item_t;

endpackage

`default_nettype wire

@@ sv/tmb_update.sv @@
// Per-entry update of one timer: applies a command or a tick check to one entry.
// Depends on tmb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tmb_update (
  input  wire tmb_pkg::item_t  item,
  input  wire tmb_pkg::entry_t cur,
  output tmb_pkg::entry_t      nxt,
  output logic                 fire
);

  logic [tmb_pkg::PER_W-1:0]  add_per;
  logic [tmb_pkg::TIME_W:0]   sum;
  logic [tmb_pkg::TIME_W-1:0] sat;
  logic signed [tmb_pkg::PER_W:0] diff;
  logic signed [tmb_pkg::PER_W:0] floor_s;

  assign add_per = (item.op == tmb_pkg::OP_REGISTER) ? item.interval : cur.period;
  assign sum     = {1'b0, item.now} + {{(tmb_pkg::TIME_W + 1 - tmb_pkg::PER_W){1'b0}}, add_per};
  // saturate at the top of the time range
  assign sat     = sum[tmb_pkg::TIME_W] ? {tmb_pkg::TIME_W{1'b1}} : sum[tmb_pkg::TIME_W-1:0];
  assign diff    = $signed({1'b0, cur.period}) - $signed({1'b0, item.amount});
  assign floor_s = $signed({1'b0, item.minimum});

  always_comb begin
    nxt  = cur;
    fire = 1'b0;
    case (item.op)
      tmb_pkg::OP_TICK: begin
        if (cur.armed && (item.now >= cur.deadline)) begin
          fire = 1'b1;
          if (cur.repeat_flag) begin
            nxt.deadline = sat;
          end else begin
            nxt.armed = 1'b0;
          end
        end
      end
      tmb_pkg::OP_REGISTER: begin
        nxt.period      = item.interval;
        nxt.repeat_flag = item.recurring;
        nxt.deadline    = sat;
        nxt.armed       = 1'b1;
      end
      tmb_pkg::OP_ENABLE: begin
        nxt.armed       = 1'b1;
        nxt.deadline    = sat;
        nxt.repeat_flag = item.recurring;
      end
      tmb_pkg::OP_DISABLE: begin
        nxt.armed = 1'b0;
      end
      tmb_pkg::OP_DECREASE: begin
        if (diff >= floor_s) begin
          nxt.period = diff[tmb_pkg::PER_W-1:0];
        end else begin
          nxt.period = item.minimum;
        end
      end
      tmb_pkg::OP_TRIGGER: begin
        nxt.deadline = item.now;
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ sv/multi_timer_bank_core.sv @@
// Multi-timer bank: timer state memory, command/tick sequencer and result register.
// Depends on tmb_pkg, tmb_update and assert_macros.svh.
//
// Usage:
//  - Input channel (in_valid/in_ready) carries one operation per transaction: a tick
//    or a command (register, enable, disable, decrease, trigger) for timer in_timer_sel.
//  - Result channel (out_valid/out_ready) carries out_fired_mask, one per tick only.
//    Commands, unknown operations and out-of-range selects give no result.
//  - Timer state sits in a single-port-write, registered-read memory of TIMER_COUNT
//    entries; every command or tick reads entries, updates them and writes them back.
//  - A command reads its entry on acceptance, then updates it and writes it back in
//    ST_CMD before the next transaction can be taken.
//  - A tick walks the entries one per cycle, read of entry k overlapping write-back of
//    entry k-1, then loads the mask into the output register in ST_DONE, from which it
//    appears on out_*. The registered memory read port sets this overlap.
//  - The mask waits in an output register; while it is not taken, commands and
//    further ticks still proceed until a second mask is ready, which then holds the
//    sequencer until the first one has gone.
//  - Reset (rst_n low, synchronous) clears the per-entry valid bits, so every timer
//    reads as all zero and disarmed; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module multi_timer_bank_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_operation,
  input  wire logic [3:0]  in_timer_sel,
  input  wire logic [47:0] in_now,
  input  wire logic [30:0] in_interval_in,
  input  wire logic        in_recurring_in,
  input  wire logic [30:0] in_amount,
  input  wire logic [30:0] in_minimum,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      out_fired_mask
);

  tmb_pkg::state_t state_r, state_nxt;
  tmb_pkg::item_t  item_r, in_item;
  tmb_pkg::entry_t mem [tmb_pkg::TIMER_COUNT];
  tmb_pkg::entry_t rd_data_r, cur_entry, new_entry;
  logic [tmb_pkg::TIMER_COUNT-1:0] valid_r;
  logic                            rd_vld_r;
  logic [tmb_pkg::CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [tmb_pkg::MASK_W-1:0]      mask_r, mask_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [tmb_pkg::MASK_W-1:0]      out_mask_r;
  logic                            fire;
  logic                            accept, is_cmd, sel_ok, load_out;
  logic                            rd_en, wr_en;
  logic [tmb_pkg::IDX_W-1:0]       rd_addr, wr_addr, proc_idx;

  assign in_item.op        = tmb_pkg::op_t'(in_operation);
  assign in_item.sel       = in_timer_sel;
  assign in_item.now       = in_now;
  assign in_item.interval  = in_interval_in;
  assign in_item.recurring = in_recurring_in;
  assign in_item.amount    = in_amount;
  assign in_item.minimum   = in_minimum;

  assign accept = in_valid && in_ready;
  assign sel_ok = {2'b00, in_timer_sel} < 6'(tmb_pkg::TIMER_COUNT);
  assign is_cmd = (in_item.op inside {tmb_pkg::OP_REGISTER, tmb_pkg::OP_ENABLE,
                   tmb_pkg::OP_DISABLE, tmb_pkg::OP_DECREASE, tmb_pkg::OP_TRIGGER}) && sel_ok;

  assign proc_idx  = tmb_pkg::IDX_W'(cnt_r - tmb_pkg::CNT_W'(1));
  assign cur_entry = rd_vld_r ? rd_data_r : '0;

  tmb_update u_update (
    .item (item_r),
    .cur  (cur_entry),
    .nxt  (new_entry),
    .fire (fire)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tmb_pkg::ST_IDLE: begin
        if (accept && (in_item.op == tmb_pkg::OP_TICK)) begin
          state_nxt = tmb_pkg::ST_SCAN;
        end else if (accept && is_cmd) begin
          state_nxt = tmb_pkg::ST_CMD;
        end
      end
      tmb_pkg::ST_CMD: state_nxt = tmb_pkg::ST_IDLE;
      tmb_pkg::ST_SCAN: begin
        if (cnt_r == tmb_pkg::CNT_W'(tmb_pkg::TIMER_COUNT)) begin
          state_nxt = tmb_pkg::ST_DONE;
        end
      end
      tmb_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = tmb_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tmb_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready = 1'b0;
    rd_en    = 1'b0;
    rd_addr  = '0;
    wr_en    = 1'b0;
    wr_addr  = '0;
    cnt_nxt  = cnt_r;
    mask_nxt = mask_r;
    load_out = 1'b0;
    case (state_r)
      tmb_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        rd_en    = in_valid && is_cmd;
        rd_addr  = tmb_pkg::IDX_W'(in_timer_sel);
        cnt_nxt  = '0;
        mask_nxt = '0;
      end
      tmb_pkg::ST_CMD: begin
        wr_en   = 1'b1;
        wr_addr = tmb_pkg::IDX_W'(item_r.sel);
      end
      tmb_pkg::ST_SCAN: begin
        rd_en   = cnt_r != tmb_pkg::CNT_W'(tmb_pkg::TIMER_COUNT);
        rd_addr = tmb_pkg::IDX_W'(cnt_r);
        cnt_nxt = cnt_r + tmb_pkg::CNT_W'(1);
        if (cnt_r != '0) begin
          wr_en    = 1'b1;
          wr_addr  = proc_idx;
          mask_nxt = mask_r | (tmb_pkg::MASK_W'(fire) << proc_idx);
        end
      end
      tmb_pkg::ST_DONE: begin
        load_out = !out_valid_r || out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign out_valid_nxt = (out_valid_r && !out_ready) || load_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tmb_pkg::ST_IDLE;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      mask_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      mask_r      <= mask_nxt;
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
    end
    if (load_out) begin
      out_mask_r <= mask_r;
    end
  end

  // timer state memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= new_entry;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
      rd_vld_r  <= valid_r[rd_addr];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_fired_mask = out_mask_r;

  `TMB_ASSERT_IMPL(a_no_rw_clash, clk, rst_n, rd_en && wr_en, rd_addr != wr_addr, "read and write-back hit the same timer entry")
  `TMB_ASSERT_IMPL(a_result_from_done, clk, rst_n, $rose(out_valid_r), $past(state_r) == tmb_pkg::ST_DONE, "result raised outside tick completion")
  `TMB_ASSERT_NEXT(a_cmd_no_result, clk, rst_n, accept && (in_item.op != tmb_pkg::OP_TICK), !$rose(out_valid_r), "command transaction produced a result")

endmodule

`default_nettype wire
